/* rtl/gaps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Greedy age point suppression package
// Field widths shared by the channels and the block, and the gap reset value.
// ----------------------------------------------------------------------------
package gaps_pkg;

   localparam int COORD_W = 16;
   localparam int AGE_W   = 16;
   localparam int GAP_W   = 8;

   localparam logic [GAP_W-1:0] GAP_RESET = 8'd8;

endpackage
`default_nettype wire

/* rtl/gaps_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Greedy age point suppression channels
// Point input, kept point result and gap register write channels.
// ----------------------------------------------------------------------------
interface gaps_req_if import gaps_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] point_x;
   logic signed [COORD_W-1:0] point_y;
   logic [AGE_W-1:0]          point_age;
   logic                      last_point;

   modport source (output valid, point_x, point_y, point_age, last_point, input ready);
   modport sink   (input valid, point_x, point_y, point_age, last_point, output ready);
endinterface

interface gaps_rsp_if import gaps_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] kept_x;
   logic signed [COORD_W-1:0] kept_y;
   logic [AGE_W-1:0]          kept_age;
   logic                      last_kept;
   logic                      overflowed;

   modport source (output valid, kept_x, kept_y, kept_age, last_kept, overflowed, input ready);
   modport sink   (input valid, kept_x, kept_y, kept_age, last_kept, overflowed, output ready);
endinterface

interface gaps_csr_if import gaps_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [GAP_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

/* rtl/gaps_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gaps_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

/* rtl/greedy_age_point_suppression.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Greedy age point suppression
// Loads a set of points, then keeps the oldest that lie at least 16 * gap apart.
// ----------------------------------------------------------------------------
// Points arrive on req_chan, one per transfer, and are stored until the transfer
// marked last_point; points beyond MAX_POINTS are dropped and flagged. req_chan
// stays ready throughout loading. The set is then processed by one shared
// sequencer: each survivor costs a selection scan over the n stored points and
// a suppression pass that reads every stored point and, for each point still
// pending, has the single shared multiplier square both differences in turn.
// No point is accepted meanwhile. Survivors leave on rsp_chan oldest first, the
// final one marked by last_kept. One result is held back so that the final one
// can be marked, and the output register holds a result until the receiver
// takes it; a stalled receiver pauses the sequencer only when a held result
// must move on to the output register. The gap register is written on
// csr_chan, which is always ready. Reset empties the set and sets gap to 8; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module greedy_age_point_suppression import gaps_pkg::*; #(
   parameter int MAX_POINTS = 64
) (
   input wire logic   clock,
   input wire logic   reset,
   gaps_req_if.sink   req_chan,
   gaps_rsp_if.source rsp_chan,
   gaps_csr_if.sink   csr_chan
);

   localparam int AW    = $clog2(MAX_POINTS);
   localparam int CW    = $clog2(MAX_POINTS + 1);
   localparam int MUL_W = COORD_W + 1;
   localparam int SQ_W  = 2 * COORD_W;

   typedef enum logic [11:0] {
      ST_LOAD  = 12'b0000_0000_0001,
      ST_LIMIT = 12'b0000_0000_0010,
      ST_SCAN  = 12'b0000_0000_0100,
      ST_PREAD = 12'b0000_0000_1000,
      ST_PICK  = 12'b0000_0001_0000,
      ST_PUSH  = 12'b0000_0010_0000,
      ST_SRD   = 12'b0000_0100_0000,
      ST_SDX   = 12'b0000_1000_0000,
      ST_SMX   = 12'b0001_0000_0000,
      ST_SMY   = 12'b0010_0000_0000,
      ST_SCMP  = 12'b0100_0000_0000,
      ST_FINAL = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [GAP_W-1:0]       gap_ff, gap_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   ovf_ff, ovf_in;
   logic [2*GAP_W-1:0]     gsq_ff, gsq_in;
   logic [CW-1:0]          sc_addr_ff, sc_addr_in;
   logic                   sc_vld_ff, sc_vld_in;
   logic [AW-1:0]          sc_idx_ff, sc_idx_in;
   logic                   found_ff, found_in;
   logic [AW-1:0]          best_idx_ff, best_idx_in;
   logic [AGE_W-1:0]       best_age_ff, best_age_in;
   logic [COORD_W-1:0]     px_ff, px_in;
   logic [COORD_W-1:0]     py_ff, py_in;
   logic [AW-1:0]          j_ff, j_in;
   logic signed [MUL_W-1:0] dx_ff, dx_in;
   logic signed [MUL_W-1:0] dy_ff, dy_in;
   logic [SQ_W-1:0]        sqx_ff, sqx_in;
   logic [SQ_W-1:0]        sqy_ff, sqy_in;
   logic                   hold_vld_ff, hold_vld_in;
   logic [COORD_W-1:0]     hold_x_ff, hold_x_in;
   logic [COORD_W-1:0]     hold_y_ff, hold_y_in;
   logic [AGE_W-1:0]       hold_age_ff, hold_age_in;
   logic                   rsp_vld_ff, rsp_vld_in;
   logic [COORD_W-1:0]     rsp_x_ff, rsp_x_in;
   logic [COORD_W-1:0]     rsp_y_ff, rsp_y_in;
   logic [AGE_W-1:0]       rsp_age_ff, rsp_age_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   logic                   req_fire;
   logic                   slot_free;
   logic                   j_last;
   logic                   pt_we;
   logic                   pend_we;
   logic [AW-1:0]          pend_wa;
   logic                   pend_wd;
   logic [AW-1:0]          rd_addr;
   logic [COORD_W-1:0]     x_rd;
   logic [COORD_W-1:0]     y_rd;
   logic [AGE_W-1:0]       age_rd;
   logic                   pend_rd;
   logic signed [MUL_W-1:0]   mul_a;
   logic signed [MUL_W-1:0]   mul_b;
   logic signed [2*MUL_W-1:0] mul_p;
   logic [SQ_W:0]          dist_sq;
   logic [SQ_W:0]          limit;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign slot_free = !rsp_vld_ff || rsp_chan.ready;
   assign j_last    = (CW'(j_ff) + CW'(1)) == count_ff;
   assign dist_sq   = (SQ_W + 1)'(sqx_ff) + (SQ_W + 1)'(sqy_ff);
   assign limit     = (SQ_W + 1)'({gsq_ff, 8'd0});

   assign req_chan.ready = (state_ff == ST_LOAD);
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid      = rsp_vld_ff;
   assign rsp_chan.kept_x     = rsp_x_ff;
   assign rsp_chan.kept_y     = rsp_y_ff;
   assign rsp_chan.kept_age   = rsp_age_ff;
   assign rsp_chan.last_kept  = rsp_last_ff;
   assign rsp_chan.overflowed = rsp_ovf_ff;

   always_comb begin
      unique case (state_ff)
         ST_LIMIT: begin
            mul_a = MUL_W'(gap_ff);
            mul_b = MUL_W'(gap_ff);
         end
         ST_SMY: begin
            mul_a = dy_ff;
            mul_b = dy_ff;
         end
         default: begin
            mul_a = dx_ff;
            mul_b = dx_ff;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      unique case (state_ff)
         ST_SCAN:  rd_addr = sc_addr_ff[AW-1:0];
         ST_PREAD: rd_addr = best_idx_ff;
         ST_PICK:  rd_addr = best_idx_ff;
         default:  rd_addr = j_ff;
      endcase
   end

   gaps_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_x_ram (
      .clock   (clock),
      .wr_en   (pt_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_chan.point_x),
      .rd_addr (rd_addr),
      .rd_data (x_rd)
   );

   gaps_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_y_ram (
      .clock   (clock),
      .wr_en   (pt_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_chan.point_y),
      .rd_addr (rd_addr),
      .rd_data (y_rd)
   );

   gaps_ram #(.WIDTH(AGE_W), .DEPTH(MAX_POINTS)) u_age_ram (
      .clock   (clock),
      .wr_en   (pt_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_chan.point_age),
      .rd_addr (rd_addr),
      .rd_data (age_rd)
   );

   gaps_ram #(.WIDTH(1), .DEPTH(MAX_POINTS)) u_pend_ram (
      .clock   (clock),
      .wr_en   (pend_we),
      .wr_addr (pend_wa),
      .wr_data (pend_wd),
      .rd_addr (rd_addr),
      .rd_data (pend_rd)
   );

   always_comb begin
      state_in    = state_ff;
      gap_in      = gap_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      gsq_in      = gsq_ff;
      sc_addr_in  = sc_addr_ff;
      sc_vld_in   = sc_vld_ff;
      sc_idx_in   = sc_idx_ff;
      found_in    = found_ff;
      best_idx_in = best_idx_ff;
      best_age_in = best_age_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      j_in        = j_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      sqx_in      = sqx_ff;
      sqy_in      = sqy_ff;
      hold_vld_in = hold_vld_ff;
      hold_x_in   = hold_x_ff;
      hold_y_in   = hold_y_ff;
      hold_age_in = hold_age_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_chan.ready;
      rsp_x_in    = rsp_x_ff;
      rsp_y_in    = rsp_y_ff;
      rsp_age_in  = rsp_age_ff;
      rsp_last_in = rsp_last_ff;
      rsp_ovf_in  = rsp_ovf_ff;
      pt_we       = 1'b0;
      pend_we     = 1'b0;
      pend_wa     = j_ff;
      pend_wd     = 1'b0;

      if (csr_chan.valid) begin
         gap_in = csr_chan.data;
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (count_ff < CW'(MAX_POINTS)) begin
                  pt_we    = 1'b1;
                  pend_we  = 1'b1;
                  pend_wa  = count_ff[AW-1:0];
                  pend_wd  = 1'b1;
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_chan.last_point) begin
                  state_in = ST_LIMIT;
               end
            end
         end
         ST_LIMIT: begin
            gsq_in     = mul_p[2*GAP_W-1:0];
            sc_addr_in = '0;
            sc_vld_in  = 1'b0;
            found_in   = 1'b0;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            if (sc_addr_ff != count_ff) begin
               sc_addr_in = sc_addr_ff + CW'(1);
               sc_vld_in  = 1'b1;
               sc_idx_in  = sc_addr_ff[AW-1:0];
            end else begin
               sc_vld_in = 1'b0;
            end
            if (sc_vld_ff && pend_rd && (!found_ff || age_rd > best_age_ff)) begin
               found_in    = 1'b1;
               best_idx_in = sc_idx_ff;
               best_age_in = age_rd;
            end
            if (sc_addr_ff == count_ff && !sc_vld_ff) begin
               state_in = found_ff ? ST_PREAD : ST_FINAL;
            end
         end
         ST_PREAD: begin
            state_in = ST_PICK;
         end
         ST_PICK: begin
            px_in    = x_rd;
            py_in    = y_rd;
            pend_we  = 1'b1;
            pend_wa  = best_idx_ff;
            pend_wd  = 1'b0;
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (!hold_vld_ff || slot_free) begin
               if (hold_vld_ff) begin
                  rsp_vld_in  = 1'b1;
                  rsp_x_in    = hold_x_ff;
                  rsp_y_in    = hold_y_ff;
                  rsp_age_in  = hold_age_ff;
                  rsp_last_in = 1'b0;
                  rsp_ovf_in  = ovf_ff;
               end
               hold_vld_in = 1'b1;
               hold_x_in   = px_ff;
               hold_y_in   = py_ff;
               hold_age_in = best_age_ff;
               j_in        = '0;
               state_in    = ST_SRD;
            end
         end
         ST_SRD: begin
            state_in = ST_SDX;
         end
         ST_SDX: begin
            dx_in = $signed({x_rd[COORD_W-1], x_rd}) - $signed({px_ff[COORD_W-1], px_ff});
            dy_in = $signed({y_rd[COORD_W-1], y_rd}) - $signed({py_ff[COORD_W-1], py_ff});
            if (pend_rd) begin
               state_in = ST_SMX;
            end else if (j_last) begin
               sc_addr_in = '0;
               sc_vld_in  = 1'b0;
               found_in   = 1'b0;
               state_in   = ST_SCAN;
            end else begin
               j_in     = j_ff + AW'(1);
               state_in = ST_SRD;
            end
         end
         ST_SMX: begin
            sqx_in   = mul_p[SQ_W-1:0];
            state_in = ST_SMY;
         end
         ST_SMY: begin
            sqy_in   = mul_p[SQ_W-1:0];
            state_in = ST_SCMP;
         end
         ST_SCMP: begin
            if (dist_sq < limit) begin
               pend_we = 1'b1;
               pend_wa = j_ff;
               pend_wd = 1'b0;
            end
            if (j_last) begin
               sc_addr_in = '0;
               sc_vld_in  = 1'b0;
               found_in   = 1'b0;
               state_in   = ST_SCAN;
            end else begin
               j_in     = j_ff + AW'(1);
               state_in = ST_SRD;
            end
         end
         ST_FINAL: begin
            if (slot_free) begin
               rsp_vld_in  = 1'b1;
               rsp_x_in    = hold_x_ff;
               rsp_y_in    = hold_y_ff;
               rsp_age_in  = hold_age_ff;
               rsp_last_in = 1'b1;
               rsp_ovf_in  = ovf_ff;
               hold_vld_in = 1'b0;
               count_in    = '0;
               ovf_in      = 1'b0;
               state_in    = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         gap_ff      <= GAP_RESET;
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
         sc_vld_ff   <= 1'b0;
         hold_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         gap_ff      <= gap_in;
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
         sc_vld_ff   <= sc_vld_in;
         hold_vld_ff <= hold_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      gsq_ff      <= gsq_in;
      sc_addr_ff  <= sc_addr_in;
      sc_idx_ff   <= sc_idx_in;
      found_ff    <= found_in;
      best_idx_ff <= best_idx_in;
      best_age_ff <= best_age_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      j_ff        <= j_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      sqx_ff      <= sqx_in;
      sqy_ff      <= sqy_in;
      hold_x_ff   <= hold_x_in;
      hold_y_ff   <= hold_y_in;
      hold_age_ff <= hold_age_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_age_ff  <= rsp_age_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

endmodule
`default_nettype wire
